[src/utf8_cyrillic_lcd_code_mapper_defines.svh]
// Assertion macros shared by the checker.
`ifndef UTF8_CYRILLIC_LCD_CODE_MAPPER_DEFINES_SVH
`define UTF8_CYRILLIC_LCD_CODE_MAPPER_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define ULCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by reset.
`define ULCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ulcd_pkg.sv]
package ulcd_pkg;

  typedef logic [1:0] lead_t;

  localparam lead_t LEAD_NONE = 2'd0;
  localparam lead_t LEAD_D0   = 2'd1;
  localparam lead_t LEAD_D1   = 2'd2;

  localparam logic [7:0] BYTE_D0     = 8'hD0;
  localparam logic [7:0] BYTE_D1     = 8'hD1;
  localparam logic [7:0] CODE_YO_CAP = 8'hA2;
  localparam logic [7:0] CODE_YO_SML = 8'hB5;
  localparam logic [5:0] SFX_YO_CAP  = 6'h01;
  localparam logic [5:0] SFX_YO_SML  = 6'h11;
  localparam logic [5:0] SFX_SPLIT   = 6'h10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] letter_code(input logic [5:0] idx);
    logic [7:0] code;
    case (idx)
      6'd0:  code = 8'h70;  6'd1:  code = 8'h63;  6'd2:  code = 8'hbf;  6'd3:  code = 8'h79;
      6'd4:  code = 8'he4;  6'd5:  code = 8'h78;  6'd6:  code = 8'he5;  6'd7:  code = 8'hc0;
      6'd8:  code = 8'hc1;  6'd9:  code = 8'he6;  6'd10: code = 8'hc2;  6'd11: code = 8'hc3;
      6'd12: code = 8'hc4;  6'd13: code = 8'hc5;  6'd14: code = 8'hc6;  6'd15: code = 8'hc7;
      6'd16: code = 8'h41;  6'd17: code = 8'ha0;  6'd18: code = 8'h42;  6'd19: code = 8'ha1;
      6'd20: code = 8'he0;  6'd21: code = 8'h45;  6'd22: code = 8'ha3;  6'd23: code = 8'ha4;
      6'd24: code = 8'ha5;  6'd25: code = 8'ha6;  6'd26: code = 8'h4b;  6'd27: code = 8'ha7;
      6'd28: code = 8'h4d;  6'd29: code = 8'h48;  6'd30: code = 8'h4f;  6'd31: code = 8'ha8;
      6'd32: code = 8'h50;  6'd33: code = 8'h43;  6'd34: code = 8'h54;  6'd35: code = 8'ha9;
      6'd36: code = 8'haa;  6'd37: code = 8'h58;  6'd38: code = 8'he1;  6'd39: code = 8'hab;
      6'd40: code = 8'hac;  6'd41: code = 8'he2;  6'd42: code = 8'had;  6'd43: code = 8'hae;
      6'd44: code = 8'h62;  6'd45: code = 8'haf;  6'd46: code = 8'hb0;  6'd47: code = 8'hb1;
      6'd48: code = 8'h61;  6'd49: code = 8'hb2;  6'd50: code = 8'hb3;  6'd51: code = 8'hb4;
      6'd52: code = 8'he3;  6'd53: code = 8'h65;  6'd54: code = 8'hb6;  6'd55: code = 8'hb7;
      6'd56: code = 8'hb8;  6'd57: code = 8'hb9;  6'd58: code = 8'hba;  6'd59: code = 8'hbb;
      6'd60: code = 8'hbc;  6'd61: code = 8'hbd;  6'd62: code = 8'h6f;  6'd63: code = 8'hbe;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

[src/utf8_cyrillic_lcd_code_mapper.sv]
// Channel | Dir | Payload
// in_     | in  | tdata[7:0] byte_in
// out_    | out | tdata[7:0] lcd_code, tlast last
//
// One input word a cycle if the queue has room; a two-code byte needs both slots free.
// Accepted bytes pass through the input register, then the output queue.
// The input register feeds the decoder; a two-word output queue sits behind it.
// Reset (rst_n low, synchronous) drops the held lead byte and empties both stages.
// Output stalls back up into the input register only when the queue lacks room.
module utf8_cyrillic_lcd_code_mapper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] lcd_code
  output logic       out_tlast
);

  logic              in_valid_r;
  logic [7:0]        byte_r;
  ulcd_pkg::lead_t   pend_r, pend_nxt;
  ulcd_pkg::push_t   dec_res;
  ulcd_pkg::push_t   push;
  logic [1:0]        space;
  logic              move;
  ulcd_pkg::result_t out_res;

  ulcd_decode u_dec (
    .byte_in  (byte_r),
    .pend     (pend_r),
    .res      (dec_res),
    .pend_nxt (pend_nxt)
  );

  always_comb begin
    move      = in_valid_r && (dec_res.cnt <= space);
    in_tready = !in_valid_r || move;
    push      = dec_res;
    if (!move) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      pend_r     <= ulcd_pkg::LEAD_NONE;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (move) begin
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  ulcd_outq u_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.code;
  assign out_tlast = out_res.last;

endmodule

[src/ulcd_decode.sv]
module ulcd_decode (
  input  logic [7:0]      byte_in,
  input  ulcd_pkg::lead_t pend,
  output ulcd_pkg::push_t res,
  output ulcd_pkg::lead_t pend_nxt
);

  logic       second;
  logic [7:0] lead_byte;
  logic [5:0] sfx;
  logic       cont;
  logic       yo_cap;
  logic       yo_sml;
  logic       letter;
  logic       is_lead;
  logic [7:0] mapped;
  ulcd_pkg::lead_t new_lead;

  always_comb begin
    second    = (pend != ulcd_pkg::LEAD_D0);
    lead_byte = second ? ulcd_pkg::BYTE_D1 : ulcd_pkg::BYTE_D0;
    sfx       = byte_in[5:0];
    cont      = (byte_in[7:6] == 2'b10);
    yo_cap    = !second && (sfx == ulcd_pkg::SFX_YO_CAP);
    yo_sml    = second && (sfx == ulcd_pkg::SFX_YO_SML);
    letter    = (!second && (sfx >= ulcd_pkg::SFX_SPLIT)) ||
                (second && (sfx < ulcd_pkg::SFX_SPLIT)) || yo_cap || yo_sml;
    is_lead   = (byte_in == ulcd_pkg::BYTE_D0) || (byte_in == ulcd_pkg::BYTE_D1);
    new_lead  = (byte_in == ulcd_pkg::BYTE_D0) ? ulcd_pkg::LEAD_D0 : ulcd_pkg::LEAD_D1;
    mapped    = yo_cap ? ulcd_pkg::CODE_YO_CAP :
                (yo_sml ? ulcd_pkg::CODE_YO_SML : ulcd_pkg::letter_code(sfx));

    res.cnt     = 2'd0;
    res.r0      = '{code: byte_in, last: 1'b1};
    res.r1      = '{code: byte_in, last: 1'b1};
    pend_nxt    = ulcd_pkg::LEAD_NONE;

    if (pend != ulcd_pkg::LEAD_NONE) begin
      if (cont && letter) begin
        res.cnt = 2'd1;
        res.r0  = '{code: mapped, last: 1'b1};
      end else if (is_lead) begin
        res.cnt  = 2'd1;
        res.r0   = '{code: lead_byte, last: 1'b1};
        pend_nxt = new_lead;
      end else begin
        res.cnt = 2'd2;
        res.r0  = '{code: lead_byte, last: 1'b0};
      end
    end else if (is_lead) begin
      pend_nxt = new_lead;
    end else begin
      res.cnt = 2'd1;
    end
  end

endmodule

[src/ulcd_outq.sv]
module ulcd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  ulcd_pkg::push_t   push,
  output logic [1:0]        space,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ulcd_pkg::result_t out_res
);

  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        rem_cnt;
  logic              pop;
  ulcd_pkg::result_t q_r [2];
  ulcd_pkg::result_t q_nxt [2];
  ulcd_pkg::result_t rem0;

  always_comb begin
    pop      = (cnt_r != 2'd0) && out_tready;
    rem0     = pop ? q_r[1] : q_r[0];
    rem_cnt  = cnt_r - {1'b0, pop};
    space    = 2'd2 - rem_cnt;
    q_nxt[0] = (rem_cnt == 2'd0) ? push.r0 : rem0;
    case (rem_cnt)
      2'd0:    q_nxt[1] = push.r1;
      2'd1:    q_nxt[1] = push.r0;
      default: q_nxt[1] = q_r[1];
    endcase
    cnt_nxt  = rem_cnt + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_res    = q_r[0];

endmodule

[src/ulcd_checker.sv]
`include "utf8_cyrillic_lcd_code_mapper_defines.svh"

module ulcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `ULCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed while stalled")

  `ULCD_ASSERT_NOW(a_nonlast_is_lead, out_tvalid && !out_tlast, out_tdata == ulcd_pkg::BYTE_D0 || out_tdata == ulcd_pkg::BYTE_D1, "non-final word is not a lead byte")

  `ULCD_ASSERT_NOW(a_stall_needs_backlog, !in_tready, out_tvalid, "input stalled with empty output queue")

endmodule

bind utf8_cyrillic_lcd_code_mapper ulcd_checker u_chk (.*);

[dv/lcd_code_checker.sv]
module lcd_code_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] lcd_code
  input  logic       out_tlast,
  output int         err_count,
  output int         codes_due,
  output int         codes_checked
);

  logic [7:0]        letter_rom [0:63];
  ulcd_pkg::lead_t   held_lead;
  ulcd_pkg::result_t pending_codes [$];
  int                err_total;
  int                checked_total;

  initial begin
    letter_rom = '{
      8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
      8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
      8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
      8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
      8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
      8'hac, 8'he2, 8'had, 8'hae, 8'h62, 8'haf, 8'hb0, 8'hb1,
      8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
      8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe
    };
    held_lead     = ulcd_pkg::LEAD_NONE;
    err_total     = 0;
    checked_total = 0;
  end

  task automatic push_code(input logic [7:0] code, input logic last);
    ulcd_pkg::result_t r;
    r.code = code;
    r.last = last;
    pending_codes.push_back(r);
  endtask

  task automatic map_byte(input logic [7:0] b);
    logic       second;
    logic [7:0] lead_byte;
    logic [5:0] sfx;
    logic       yo_cap;
    logic       yo_small;
    logic       is_letter;
    logic       flush;
    second    = (held_lead != ulcd_pkg::LEAD_D0);
    lead_byte = second ? ulcd_pkg::BYTE_D1 : ulcd_pkg::BYTE_D0;
    sfx       = b[5:0];
    yo_cap    = !second && (sfx == ulcd_pkg::SFX_YO_CAP);
    yo_small  = second && (sfx == ulcd_pkg::SFX_YO_SML);
    is_letter = (!second && sfx >= ulcd_pkg::SFX_SPLIT) ||
                (second && sfx < ulcd_pkg::SFX_SPLIT) || yo_cap || yo_small;
    flush     = (held_lead != ulcd_pkg::LEAD_NONE);
    if (flush && b[7:6] == 2'b10 && is_letter) begin
      push_code(yo_cap ? ulcd_pkg::CODE_YO_CAP :
                (yo_small ? ulcd_pkg::CODE_YO_SML : letter_rom[sfx]), 1'b1);
      held_lead = ulcd_pkg::LEAD_NONE;
    end else if (b == ulcd_pkg::BYTE_D0 || b == ulcd_pkg::BYTE_D1) begin
      if (flush) push_code(lead_byte, 1'b1);
      held_lead = (b == ulcd_pkg::BYTE_D0) ? ulcd_pkg::LEAD_D0 : ulcd_pkg::LEAD_D1;
    end else begin
      if (flush) push_code(lead_byte, 1'b0);
      push_code(b, 1'b1);
      held_lead = ulcd_pkg::LEAD_NONE;
    end
  endtask

  always @(posedge clk) begin
    ulcd_pkg::result_t want;
    if (!rst_n) begin
      held_lead = ulcd_pkg::LEAD_NONE;
      pending_codes.delete();
    end else begin
      if (in_tvalid && in_tready) map_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (pending_codes.size() == 0) begin
          $display("%0t: unexpected word, expected none, got code %h last %b",
                   $time, out_tdata, out_tlast);
          err_total++;
        end else begin
          want = pending_codes.pop_front();
          if (out_tdata !== want.code) begin
            $display("%0t: lcd_code mismatch, expected %h, got %h",
                     $time, want.code, out_tdata);
            err_total++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %b, got %b",
                     $time, want.last, out_tlast);
            err_total++;
          end
          checked_total++;
        end
      end
    end
    err_count     <= err_total;
    codes_due     <= pending_codes.size();
    codes_checked <= checked_total;
  end

endmodule

[dv/testbench.sv]
module testbench;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata  = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int err_count;
  int codes_due;
  int codes_checked;
  int send_idle = 26;
  int recv_idle = 54;
  int bytes_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_cyrillic_lcd_code_mapper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lcd_code_checker code_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .err_count     (err_count),
    .codes_due     (codes_due),
    .codes_checked (codes_checked)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_letter();
    if ($urandom_range(1)) begin
      send_byte(ulcd_pkg::BYTE_D1);
      send_byte(($urandom_range(9) == 0) ? 8'h91 : 8'($urandom_range(8'h8F, 8'h80)));
    end else begin
      send_byte(ulcd_pkg::BYTE_D0);
      send_byte(($urandom_range(9) == 0) ? 8'h81 : 8'($urandom_range(8'hBF, 8'h90)));
    end
  endtask

  task automatic send_random_group();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_letter();
    end else if (pick < 75) begin
      send_byte(8'($urandom_range(8'h7F, 8'h00)));
    end else if (pick < 85) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 93) begin
      send_byte($urandom_range(1) ? ulcd_pkg::BYTE_D1 : ulcd_pkg::BYTE_D0);
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte($urandom_range(1) ? ulcd_pkg::BYTE_D1 : ulcd_pkg::BYTE_D0);
      send_byte($urandom_range(1) ? ulcd_pkg::BYTE_D1 : ulcd_pkg::BYTE_D0);
    end
  endtask

  task automatic send_directed();
    logic [7:0] seq [0:25];
    seq = '{8'h00, 8'hFF, 8'h7F, 8'h80,
            ulcd_pkg::BYTE_D0, 8'h90, ulcd_pkg::BYTE_D0, 8'h81,
            ulcd_pkg::BYTE_D1, 8'h91, ulcd_pkg::BYTE_D1, 8'h8F,
            ulcd_pkg::BYTE_D0, 8'hBF, ulcd_pkg::BYTE_D1, 8'h80,
            ulcd_pkg::BYTE_D0, 8'h80, ulcd_pkg::BYTE_D1, 8'hBF,
            ulcd_pkg::BYTE_D0, ulcd_pkg::BYTE_D1, 8'h41,
            ulcd_pkg::BYTE_D0, 8'h8F, 8'hC0};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    int wait_cycles;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    while (bytes_sent < 300) send_random_group();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (codes_due != 0) @(posedge clk);

    send_idle = 54;
    recv_idle = 26;
    while (bytes_sent < 580) send_random_group();

    send_idle = 0;
    recv_idle = 0;
    while (bytes_sent < 860) send_random_group();
    in_tvalid <= 1'b0;

    for (wait_cycles = 0; codes_due != 0 && wait_cycles < 10000; wait_cycles++)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (codes_due != 0) $display("%0t: %0d expected codes never arrived", $time, codes_due);
    $display("Sent %0d UTF-8 bytes (letters, yo pairs, stray leads, noise) in three",
             bytes_sent);
    $display("backpressure phases plus a full drain; %0d LCD codes compared.", codes_checked);
    if (err_count == 0 && codes_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
